[rtl/assert_macros.svh]
// Assertion helpers shared by the extractor modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge outside reset.
`define CKE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CKE_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/cke_pkg.sv]
`default_nettype none

package cke_pkg;

    localparam int MAX_DIM = 4096;
    localparam int POS_W   = $clog2(MAX_DIM);
    localparam int DIM_W   = POS_W + 1;

    localparam int KEY_W     = 24;
    localparam int BYTE_W    = 8;
    localparam int CFG_IDX_W = 3;

    localparam logic [BYTE_W-1:0] BYTE_MAX = {BYTE_W{1'b1}};

    localparam logic [DIM_W-1:0] DIM_MAX     = DIM_W'(MAX_DIM);
    localparam logic [DIM_W-1:0] DIM_ONE     = DIM_W'(1);
    localparam logic [DIM_W-1:0] BATCH_RESET = DIM_W'(2000);

    localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR   = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_KEY_TOL     = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH       = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] REG_BATCH_LIMIT = CFG_IDX_W'(4);

    localparam logic KIND_RUN   = 1'b0;
    localparam logic KIND_CLOSE = 1'b1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    localparam int S_TDATA_W = 3 * BYTE_W;
    localparam int RES_W     = 5 * DIM_W;
    localparam int M_TDATA_W = ((RES_W + 7) / 8) * 8;
    localparam int PAD_W     = M_TDATA_W - RES_W;

    typedef struct packed {
        logic             has_rect;
        logic             frame_end;
        logic [POS_W-1:0] start;
        logic [DIM_W-1:0] end_x;
        logic [POS_W-1:0] row;
    } t_event;

    typedef struct packed {
        logic             kind;
        logic [DIM_W-1:0] left;
        logic [DIM_W-1:0] top;
        logic [DIM_W-1:0] right;
        logic [DIM_W-1:0] bottom;
        logic [DIM_W-1:0] count;
        logic             done;
    } t_result;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_BATCH,
        BK_FINAL
    } t_back_state;

endpackage

`default_nettype wire

[rtl/cke_front.sv]
`default_nettype none
`include "assert_macros.svh"

module cke_front (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_pix_valid,
    output logic                                o_pix_ready,
    input  wire logic [cke_pkg::S_TDATA_W-1:0]  i_pix_data,
    input  wire logic [cke_pkg::KEY_W-1:0]      i_key_color,
    input  wire logic [cke_pkg::KEY_W-1:0]      i_key_tol,
    input  wire logic [cke_pkg::DIM_W-1:0]      i_width,
    input  wire logic [cke_pkg::DIM_W-1:0]      i_height,
    input  wire logic                           i_q_full,
    output logic                                o_push,
    output cke_pkg::t_event                     o_ev
);

    function automatic logic in_key(input logic [cke_pkg::BYTE_W-1:0] v,
                                    input logic [cke_pkg::BYTE_W-1:0] lo,
                                    input logic [cke_pkg::BYTE_W-1:0] tol);
        logic [cke_pkg::BYTE_W:0]   sum;
        logic [cke_pkg::BYTE_W-1:0] hi;
        sum = {1'b0, lo} + {1'b0, tol};
        hi  = sum[cke_pkg::BYTE_W] ? cke_pkg::BYTE_MAX : sum[cke_pkg::BYTE_W-1:0];
        return (v >= lo) && (v <= hi);
    endfunction

    function automatic logic [cke_pkg::DIM_W-1:0] clamp_dim(
        input logic [cke_pkg::DIM_W-1:0] v);
        logic [cke_pkg::DIM_W-1:0] r;
        if (v == '0) begin
            r = cke_pkg::DIM_ONE;
        end else if (v > cke_pkg::DIM_MAX) begin
            r = cke_pkg::DIM_MAX;
        end else begin
            r = v;
        end
        return r;
    endfunction

    logic [cke_pkg::POS_W-1:0] r_column, n_column;
    logic [cke_pkg::POS_W-1:0] r_row, n_row;
    logic                      r_in_run, n_in_run;
    logic [cke_pkg::POS_W-1:0] r_run_start, n_run_start;

    logic                      accept;
    logic                      clear_px;
    logic                      emit;
    logic                      last_col;
    logic                      last_row;
    logic [cke_pkg::DIM_W-1:0] col_inc;
    logic [cke_pkg::DIM_W-1:0] row_inc;
    logic [cke_pkg::POS_W-1:0] start;

    assign o_pix_ready = !i_q_full;
    assign accept      = i_pix_valid && !i_q_full;

    always_comb begin
        clear_px = in_key(i_pix_data[7:0],   i_key_color[7:0],   i_key_tol[7:0])
                && in_key(i_pix_data[15:8],  i_key_color[15:8],  i_key_tol[15:8])
                && in_key(i_pix_data[23:16], i_key_color[23:16], i_key_tol[23:16]);
        col_inc  = {1'b0, r_column} + cke_pkg::DIM_ONE;
        row_inc  = {1'b0, r_row} + cke_pkg::DIM_ONE;
        last_col = col_inc >= clamp_dim(i_width);
        last_row = row_inc >= clamp_dim(i_height);
        emit     = clear_px ? r_in_run : last_col;
        start    = (!clear_px && !r_in_run) ? r_column : r_run_start;

        o_ev.has_rect  = emit;
        o_ev.frame_end = last_col && last_row;
        o_ev.start     = start;
        o_ev.end_x     = clear_px ? {1'b0, r_column} : col_inc;
        o_ev.row       = r_row;
        o_push         = accept && (emit || (last_col && last_row));

        n_in_run    = r_in_run;
        n_run_start = r_run_start;
        n_column    = r_column;
        n_row       = r_row;
        if (accept) begin
            n_in_run    = !clear_px && !last_col;
            n_run_start = start;
            if (last_col) begin
                n_column = '0;
                n_row    = last_row ? '0 : row_inc[cke_pkg::POS_W-1:0];
            end else begin
                n_column = col_inc[cke_pkg::POS_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column    <= '0;
            r_row       <= '0;
            r_in_run    <= 1'b0;
            r_run_start <= '0;
        end else begin
            r_column    <= n_column;
            r_row       <= n_row;
            r_in_run    <= n_in_run;
            r_run_start <= n_run_start;
        end
    end

    `CKE_ASSERT(a_run_not_empty, i_clk, i_rst_n, !(o_push && o_ev.has_rect) || (o_ev.end_x > {1'b0, o_ev.start}), "run rectangle has no width")

endmodule

`default_nettype wire

[rtl/cke_queue.sv]
`default_nettype none
`include "assert_macros.svh"

module cke_queue (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_push,
    input  wire cke_pkg::t_event i_ev,
    output logic                 o_full,
    output logic                 o_valid,
    output cke_pkg::t_event      o_head,
    input  wire logic            i_pop
);

    cke_pkg::t_event            r_mem [cke_pkg::QUEUE_DEPTH];
    logic [cke_pkg::QPTR_W-1:0] r_wr_ptr;
    logic [cke_pkg::QPTR_W-1:0] r_rd_ptr;
    logic [cke_pkg::QCNT_W-1:0] r_count;
    logic                       do_push;
    logic                       do_pop;

    assign o_full  = r_count == cke_pkg::QCNT_W'(cke_pkg::QUEUE_DEPTH);
    assign o_valid = r_count != '0;
    assign o_head  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_ev;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + cke_pkg::QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + cke_pkg::QPTR_W'(1);
            end
            r_count <= r_count + cke_pkg::QCNT_W'(do_push) - cke_pkg::QCNT_W'(do_pop);
        end
    end

    `CKE_ASSERT(a_queue_bound, i_clk, i_rst_n, r_count <= cke_pkg::QCNT_W'(cke_pkg::QUEUE_DEPTH), "event queue count past depth")
    `CKE_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full), "event pushed into a full queue")

endmodule

`default_nettype wire

[rtl/cke_back.sv]
`default_nettype none
`include "assert_macros.svh"

module cke_back (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_ev_valid,
    input  wire cke_pkg::t_event            i_ev,
    output logic                            o_ev_pop,
    input  wire logic [cke_pkg::DIM_W-1:0]  i_batch_limit,
    output logic                            o_out_valid,
    input  wire logic                       i_out_ready,
    output cke_pkg::t_result                o_out
);

    cke_pkg::t_back_state      r_state, n_state;
    logic                      r_frame_end, n_frame_end;
    logic [cke_pkg::DIM_W-1:0] r_count, n_count;
    logic [cke_pkg::DIM_W-1:0] r_left, n_left;
    logic [cke_pkg::DIM_W-1:0] r_top, n_top;
    logic [cke_pkg::DIM_W-1:0] r_right, n_right;
    logic [cke_pkg::DIM_W-1:0] r_bottom, n_bottom;
    logic                      r_out_valid, n_out_valid;
    cke_pkg::t_result          r_out, n_out;

    logic                      out_free;
    logic [cke_pkg::DIM_W-1:0] ev_left;
    logic [cke_pkg::DIM_W-1:0] ev_top;
    logic [cke_pkg::DIM_W-1:0] ev_bottom;
    logic [cke_pkg::DIM_W-1:0] cnt_inc;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    always_comb begin
        ev_left   = {1'b0, i_ev.start};
        ev_top    = {1'b0, i_ev.row};
        ev_bottom = {1'b0, i_ev.row} + cke_pkg::DIM_ONE;
        cnt_inc   = r_count + cke_pkg::DIM_ONE;

        n_state     = r_state;
        n_frame_end = r_frame_end;
        n_count     = r_count;
        n_left      = r_left;
        n_top       = r_top;
        n_right     = r_right;
        n_bottom    = r_bottom;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out       = r_out;
        o_ev_pop    = 1'b0;

        n_out.kind   = cke_pkg::KIND_CLOSE;
        n_out.left   = r_left;
        n_out.top    = r_top;
        n_out.right  = r_right;
        n_out.bottom = r_bottom;
        n_out.count  = r_count;
        n_out.done   = 1'b0;
        if (!out_free) begin
            n_out = r_out;
        end

        unique case (r_state)
            cke_pkg::BK_IDLE: begin
                if (i_ev_valid && out_free) begin
                    o_ev_pop    = 1'b1;
                    n_out_valid = 1'b1;
                    n_frame_end = i_ev.frame_end;
                    if (i_ev.has_rect) begin
                        n_out.kind   = cke_pkg::KIND_RUN;
                        n_out.left   = ev_left;
                        n_out.top    = ev_top;
                        n_out.right  = i_ev.end_x;
                        n_out.bottom = ev_bottom;
                        n_out.count  = '0;
                        n_left   = (ev_left < r_left) ? ev_left : r_left;
                        n_top    = (ev_top < r_top) ? ev_top : r_top;
                        n_right  = (i_ev.end_x > r_right) ? i_ev.end_x : r_right;
                        n_bottom = (ev_bottom > r_bottom) ? ev_bottom : r_bottom;
                        n_count  = cnt_inc;
                        if (cnt_inc >= i_batch_limit) begin
                            n_state = cke_pkg::BK_BATCH;
                        end else if (i_ev.frame_end) begin
                            n_state = cke_pkg::BK_FINAL;
                        end
                    end else begin
                        n_out.done = 1'b1;
                        n_count    = '0;
                        n_left     = cke_pkg::DIM_MAX;
                        n_top      = cke_pkg::DIM_MAX;
                        n_right    = '0;
                        n_bottom   = '0;
                    end
                end
            end
            cke_pkg::BK_BATCH: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_count     = '0;
                    n_left      = cke_pkg::DIM_MAX;
                    n_top       = cke_pkg::DIM_MAX;
                    n_right     = '0;
                    n_bottom    = '0;
                    n_state     = r_frame_end ? cke_pkg::BK_FINAL : cke_pkg::BK_IDLE;
                end
            end
            cke_pkg::BK_FINAL: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out.done  = 1'b1;
                    n_count     = '0;
                    n_left      = cke_pkg::DIM_MAX;
                    n_top       = cke_pkg::DIM_MAX;
                    n_right     = '0;
                    n_bottom    = '0;
                    n_state     = cke_pkg::BK_IDLE;
                end
            end
            default: begin
                n_state = cke_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= cke_pkg::BK_IDLE;
            r_frame_end <= 1'b0;
            r_count     <= '0;
            r_left      <= cke_pkg::DIM_MAX;
            r_top       <= cke_pkg::DIM_MAX;
            r_right     <= '0;
            r_bottom    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_frame_end <= n_frame_end;
            r_count     <= n_count;
            r_left      <= n_left;
            r_top       <= n_top;
            r_right     <= n_right;
            r_bottom    <= n_bottom;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= n_out;
    end

    `CKE_ASSERT(a_done_on_close, i_clk, i_rst_n, !(r_out_valid && r_out.done) || (r_out.kind == cke_pkg::KIND_CLOSE), "frame end flagged on a run item")
    `CKE_ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, (r_state == cke_pkg::BK_FINAL) && out_free, (r_count == '0) && (r_left == cke_pkg::DIM_MAX) && (r_state == cke_pkg::BK_IDLE), "batch not cleared after final close")

endmodule

`default_nettype wire

[rtl/color_key_run_extractor_top.sv]
// Color-key run extractor.
// Pixels enter on the slave stream, one 24-bit word per transfer, in raster
// order. Each maximal run of opaque pixels in a row leaves the master stream
// as a run rectangle (tuser 0); a close item (tuser 1) carries the batch
// bounds and count whenever the count reaches the batch limit, and once more
// with tlast high after the last pixel of the frame.
// Configuration registers are written through the cfg channel, which is
// always ready; write them only while the block is idle.
// The front classifies a pixel and updates the column, row and run tracking
// in the cycle it is accepted, so one pixel is taken every cycle while the
// queue has room. Events go through a four-entry queue to the back, which
// updates the batch bounds and issues one result per cycle, while the
// receiver does not stall, into an output register.
// A pixel can cause up to three results; while the back works through them
// and the receiver stalls, the queue fills and the slave tready drops.
// Synchronous active-low reset clears the position, the batch and the
// registers to their defaults; the block accepts pixels right after reset.
`default_nettype none

module color_key_run_extractor_top (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_s_tvalid,
    output logic                                   o_s_tready,
    // pixel_byte0, pixel_byte1, pixel_byte2
    input  wire logic [cke_pkg::S_TDATA_W-1:0]     i_s_tdata,
    output logic                                   o_m_tvalid,
    input  wire logic                              i_m_tready,
    // rect_left, rect_top, rect_right, rect_bottom, batch_count, zero pad
    output logic [cke_pkg::M_TDATA_W-1:0]          o_m_tdata,
    // item_kind
    output logic                                   o_m_tuser,
    output logic                                   o_m_tlast,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [cke_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [cke_pkg::KEY_W-1:0]         i_cfg_data
);

    logic [cke_pkg::KEY_W-1:0] r_key_color;
    logic [cke_pkg::KEY_W-1:0] r_key_tol;
    logic [cke_pkg::DIM_W-1:0] r_width;
    logic [cke_pkg::DIM_W-1:0] r_height;
    logic [cke_pkg::DIM_W-1:0] r_batch_limit;

    logic             q_full;
    logic             push;
    cke_pkg::t_event  push_ev;
    logic             head_valid;
    cke_pkg::t_event  head_ev;
    logic             pop;
    cke_pkg::t_result res;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_key_color   <= '0;
            r_key_tol     <= '0;
            r_width       <= cke_pkg::DIM_MAX;
            r_height      <= cke_pkg::DIM_MAX;
            r_batch_limit <= cke_pkg::BATCH_RESET;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                cke_pkg::REG_KEY_COLOR:   r_key_color   <= i_cfg_data;
                cke_pkg::REG_KEY_TOL:     r_key_tol     <= i_cfg_data;
                cke_pkg::REG_WIDTH:       r_width       <= i_cfg_data[cke_pkg::DIM_W-1:0];
                cke_pkg::REG_HEIGHT:      r_height      <= i_cfg_data[cke_pkg::DIM_W-1:0];
                cke_pkg::REG_BATCH_LIMIT: r_batch_limit <= i_cfg_data[cke_pkg::DIM_W-1:0];
                default: begin
                end
            endcase
        end
    end

    cke_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_pix_valid (i_s_tvalid),
        .o_pix_ready (o_s_tready),
        .i_pix_data  (i_s_tdata),
        .i_key_color (r_key_color),
        .i_key_tol   (r_key_tol),
        .i_width     (r_width),
        .i_height    (r_height),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_ev        (push_ev)
    );

    cke_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_ev    (push_ev),
        .o_full  (q_full),
        .o_valid (head_valid),
        .o_head  (head_ev),
        .i_pop   (pop)
    );

    cke_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ev_valid    (head_valid),
        .i_ev          (head_ev),
        .o_ev_pop      (pop),
        .i_batch_limit (r_batch_limit),
        .o_out_valid   (o_m_tvalid),
        .i_out_ready   (i_m_tready),
        .o_out         (res)
    );

    assign o_m_tdata = {{cke_pkg::PAD_W{1'b0}}, res.count, res.bottom, res.right,
                        res.top, res.left};
    assign o_m_tuser = res.kind;
    assign o_m_tlast = res.done;

endmodule

`default_nettype wire
